// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the lidar point conversion RTL.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRPC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("lrpc assertion failed");
`define LRPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("lrpc assertion failed");
`else
`define LRPC_ASSERT(label, clk, rstn, prop)
`define LRPC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/lrpc_pkg.sv -----
// Package for the lidar range to point conversion: constants, widths and helper functions.
// Used by lrpc_cordic, the core and the testbench; depends on nothing.
`default_nettype none
package lrpc_pkg;
    localparam int MAX_COLUMNS       = 4096;
    localparam int MAX_ROWS          = 256;
    localparam int CORDIC_ITERATIONS = 24;
    localparam int REDUCE_STEPS      = 4;
    localparam int COL_W             = $clog2(MAX_COLUMNS);
    localparam int ROW_W             = $clog2(MAX_ROWS);
    localparam int ITER_W            = 5;
    localparam int CW                = 34;

    localparam logic signed [CW-1:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [CW-1:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [63:0]   HALF_Q30    = 64'sd536870912;

    localparam logic [2:0] REG_AZ_START = 3'd0;
    localparam logic [2:0] REG_AZ_STEP  = 3'd1;
    localparam logic [2:0] REG_EL_START = 3'd2;
    localparam logic [2:0] REG_EL_STEP  = 3'd3;
    localparam logic [2:0] REG_COLUMNS  = 3'd4;
    localparam logic [2:0] REG_ROWS     = 3'd5;
    localparam logic [2:0] REG_RMIN     = 3'd6;
    localparam logic [2:0] REG_RMAX     = 3'd7;

    localparam logic [31:0] RANGE_MAX_RESET = 32'd65536000;

    function automatic logic signed [CW-1:0] atan_q28(input logic [ITER_W-1:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:    v = 34'sd210828714;
            5'd1:    v = 34'sd124459457;
            5'd2:    v = 34'sd65760959;
            5'd3:    v = 34'sd33381290;
            5'd4:    v = 34'sd16755422;
            5'd5:    v = 34'sd8385879;
            5'd6:    v = 34'sd4193963;
            5'd7:    v = 34'sd2097109;
            5'd8:    v = 34'sd1048571;
            5'd9:    v = 34'sd524287;
            5'd10:   v = 34'sd262144;
            5'd11:   v = 34'sd131072;
            5'd12:   v = 34'sd65536;
            5'd13:   v = 34'sd32768;
            5'd14:   v = 34'sd16384;
            5'd15:   v = 34'sd8192;
            5'd16:   v = 34'sd4096;
            5'd17:   v = 34'sd2048;
            5'd18:   v = 34'sd1024;
            5'd19:   v = 34'sd512;
            5'd20:   v = 34'sd256;
            5'd21:   v = 34'sd128;
            5'd22:   v = 34'sd64;
            5'd23:   v = 34'sd32;
            5'd24:   v = 34'sd16;
            5'd25:   v = 34'sd8;
            5'd26:   v = 34'sd4;
            5'd27:   v = 34'sd2;
            5'd28:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Rounds a Q1.30 scaled product back by 2^30 and saturates to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + HALF_Q30) >>> 30;
        if (t > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (t < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/lrpc_mul.sv -----
// Shared signed 32 by 32 multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module lrpc_mul (
    input  wire logic               aclk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [63:0]      prod_reg
);
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end
endmodule
`default_nettype wire

// ----- rtl/lrpc_cordic.sv -----
// Iterative rotation-mode CORDIC giving cos and sin of a Q3.28 angle in Q1.30.
// Depends on lrpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lrpc_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [31:0]        angle,
    output logic                    done_reg,
    output logic                    busy_reg,
    output logic signed [31:0]      cos_out,
    output logic signed [31:0]      sin_out
);
    import lrpc_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic                 neg_reg;
    logic [2:0]           red_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic signed [CW-1:0] xn, yn;

    assign xn = neg_reg ? -x_reg : x_reg;
    assign yn = neg_reg ? -y_reg : y_reg;
    assign cos_out = xn[31:0];
    assign sin_out = yn[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            red_reg  <= '0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= CW'($signed(angle));
                neg_reg  <= 1'b0;
                red_reg  <= '0;
                iter_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (red_reg != 3'(REDUCE_STEPS)) begin
                    red_reg <= red_reg + 3'd1;
                    if (z_reg > HALF_PI_Q28) begin
                        z_reg   <= z_reg - PI_Q28;
                        neg_reg <= !neg_reg;
                    end else if (z_reg < -HALF_PI_Q28) begin
                        z_reg   <= z_reg + PI_Q28;
                        neg_reg <= !neg_reg;
                    end
                end else begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - (y_reg >>> iter_reg);
                        y_reg <= y_reg + (x_reg >>> iter_reg);
                        z_reg <= z_reg - atan_q28(iter_reg);
                    end else begin
                        x_reg <= x_reg + (y_reg >>> iter_reg);
                        y_reg <= y_reg - (x_reg >>> iter_reg);
                        z_reg <= z_reg + atan_q28(iter_reg);
                    end
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_W'(CORDIC_ITERATIONS - 1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    `LRPC_ASSERT(a_start_idle, aclk, aresetn, start |-> !busy_reg)
    `LRPC_ASSERT(a_done_ends, aclk, aresetn, done_reg |-> !busy_reg)
    `LRPC_ASSERT(a_iter_bound, aclk, aresetn, busy_reg |-> iter_reg < ITER_W'(CORDIC_ITERATIONS))
endmodule
`default_nettype wire

// ----- rtl/lidar_range_to_point_cloud_core.sv -----
// Top level of the lidar range to point conversion: register port, scan counters, sequencer.
// Depends on lrpc_pkg, lrpc_mul, lrpc_cordic and assert_macros.svh.
//
// Each range item yields one point item. In 3D mode an in-range item forms the angles in
// S_AZM, S_ELM and S_ANG on the shared 32 by 32 multiplier, runs two CORDIC passes (four range
// reduction steps and 24 rotations each) on the one shared CORDIC unit in S_CAZ and S_CEL,
// forms the coordinate products in S_M1 to S_M6 on the same multiplier and loads the output
// register in S_DONE. Other items skip the CORDIC passes and the coordinate products. The next
// item is taken as soon as the sequencer is idle, even while the previous result still waits
// on the output register; a result that cannot be loaded holds the sequencer in its last state.
// The user must read and write configuration through the APB port only while the block is
// idle; the block itself does not enforce this. The scan counters keep their values.
`default_nettype none
`include "assert_macros.svh"
module lidar_range_to_point_cloud_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_range_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_point_x,
    output logic signed [31:0]      m_point_y,
    output logic signed [31:0]      m_point_z,
    output logic                    m_in_range,
    output logic signed [31:0]      m_range_out,
    output logic                    m_last_of_scan
);
    import lrpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AZM, S_ELM, S_ANG, S_CAZ, S_CEL, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE
    } state_t;

    state_t state_reg;
    logic [31:0] az_start_reg, az_step_reg, el_start_reg, el_step_reg, rmin_reg, rmax_reg;
    logic [12:0] columns_reg;
    logic [8:0]  rows_reg;
    logic [COL_W-1:0] col_idx_reg, cidx_reg;
    logic [ROW_W-1:0] row_idx_reg, ridx_reg;
    logic signed [31:0] range_reg, az_reg, el_reg, ca_reg, sa_reg, ce_reg, se_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic ok_reg, last_reg, calc_reg, m_valid_reg;
    logic [12:0] cols_eff;
    logic [8:0]  rows_eff;
    logic col_last, row_last, in_ok, cfg_wr;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [31:0] rnd;
    logic c_start, c_done, c_busy;
    logic signed [31:0] c_cos, c_sin;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    assign cols_eff = (columns_reg == 13'd0) ? 13'd1 :
                      (columns_reg > 13'(MAX_COLUMNS)) ? 13'(MAX_COLUMNS) : columns_reg;
    assign rows_eff = (rows_reg == 9'd0) ? 9'd1 :
                      (rows_reg > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_reg;
    assign col_last = (13'(col_idx_reg) + 13'd1) >= cols_eff;
    assign row_last = (9'(row_idx_reg) + 9'd1) >= rows_eff;
    assign in_ok = (s_range_in >= $signed(rmin_reg)) && (s_range_in <= $signed(rmax_reg));
    assign rnd = round_sat(prod_reg);

    always_comb begin
        case (paddr[4:2])
            REG_AZ_START: prdata = az_start_reg;
            REG_AZ_STEP:  prdata = az_step_reg;
            REG_EL_START: prdata = el_start_reg;
            REG_EL_STEP:  prdata = el_step_reg;
            REG_COLUMNS:  prdata = {19'd0, columns_reg};
            REG_ROWS:     prdata = {23'd0, rows_reg};
            REG_RMIN:     prdata = rmin_reg;
            REG_RMAX:     prdata = rmax_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_AZM: begin
                mul_a = $signed(32'(cidx_reg));
                mul_b = $signed(az_step_reg);
            end
            S_ELM: begin
                mul_a = $signed(32'(ridx_reg));
                mul_b = $signed(el_step_reg);
            end
            S_M1, S_M3: begin
                mul_a = (state_reg == S_M1) ? ca_reg : sa_reg;
                mul_b = ce_reg;
            end
            S_M2, S_M4: begin
                mul_a = rnd;
                mul_b = range_reg;
            end
            S_M5: begin
                mul_a = se_reg;
                mul_b = range_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign c_start = ((state_reg == S_ANG) && calc_reg) || ((state_reg == S_CAZ) && c_done);

    lrpc_mul u_mul (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    lrpc_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (c_start),
        .angle    ((state_reg == S_ANG) ? az_reg : el_reg),
        .done_reg (c_done),
        .busy_reg (c_busy),
        .cos_out  (c_cos),
        .sin_out  (c_sin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            az_start_reg <= '0;
            az_step_reg  <= '0;
            el_start_reg <= '0;
            el_step_reg  <= '0;
            columns_reg  <= 13'd1;
            rows_reg     <= 9'd1;
            rmin_reg     <= '0;
            rmax_reg     <= RANGE_MAX_RESET;
            col_idx_reg  <= '0;
            row_idx_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_AZ_START: az_start_reg <= pwdata;
                    REG_AZ_STEP:  az_step_reg  <= pwdata;
                    REG_EL_START: el_start_reg <= pwdata;
                    REG_EL_STEP:  el_step_reg  <= pwdata;
                    REG_COLUMNS:  columns_reg  <= pwdata[12:0];
                    REG_ROWS:     rows_reg     <= pwdata[8:0];
                    REG_RMIN:     rmin_reg     <= pwdata;
                    REG_RMAX:     rmax_reg     <= pwdata;
                    default:      ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        range_reg <= s_range_in;
                        ok_reg    <= in_ok;
                        calc_reg  <= in_ok && (rows_eff > 9'd1);
                        last_reg  <= col_last && row_last;
                        cidx_reg  <= col_idx_reg;
                        ridx_reg  <= row_idx_reg;
                        if (col_last) begin
                            col_idx_reg <= '0;
                            row_idx_reg <= row_last ? '0 : row_idx_reg + ROW_W'(1);
                        end else begin
                            col_idx_reg <= col_idx_reg + COL_W'(1);
                        end
                        state_reg <= S_AZM;
                    end
                end
                S_AZM: state_reg <= S_ELM;
                S_ELM: begin
                    az_reg <= (cols_eff > 13'd1) ? $signed(az_start_reg + prod_reg[31:0]) : '0;
                    state_reg <= S_ANG;
                end
                S_ANG: begin
                    el_reg <= $signed(el_start_reg + prod_reg[31:0]);
                    px_reg <= '0;
                    py_reg <= '0;
                    pz_reg <= '0;
                    state_reg <= calc_reg ? S_CAZ : S_DONE;
                end
                S_CAZ: begin
                    if (c_done) begin
                        ca_reg    <= c_cos;
                        sa_reg    <= c_sin;
                        state_reg <= S_CEL;
                    end
                end
                S_CEL: begin
                    if (c_done) begin
                        ce_reg    <= c_cos;
                        se_reg    <= c_sin;
                        state_reg <= S_M1;
                    end
                end
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: begin
                    px_reg    <= rnd;
                    state_reg <= S_M4;
                end
                S_M4: state_reg <= S_M5;
                S_M5: begin
                    py_reg    <= rnd;
                    state_reg <= S_M6;
                end
                S_M6: begin
                    pz_reg    <= rnd;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_point_x      <= px_reg;
                        m_point_y      <= py_reg;
                        m_point_z      <= pz_reg;
                        m_in_range     <= ok_reg;
                        m_range_out    <= range_reg;
                        m_last_of_scan <= last_reg;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LRPC_ASSERT(a_accept_starts, aclk, aresetn, (s_valid && s_ready) |=> state_reg == S_AZM)
    `LRPC_ASSERT(a_cordic_wait, aclk, aresetn,
        c_done |-> (state_reg == S_CAZ || state_reg == S_CEL))
    `LRPC_ASSERT(a_zero_point, aclk, aresetn,
        (state_reg == S_DONE && !calc_reg && (!m_valid_reg || m_ready))
        |=> (m_point_x == 0 && m_point_y == 0 && m_point_z == 0))
    `LRPC_ASSERT(a_busy_state, aclk, aresetn,
        c_busy |-> (state_reg == S_CAZ || state_reg == S_CEL))
endmodule
`default_nettype wire

// ----- sim/lidar_range_to_point_cloud_core_tb.sv -----
// Testbench for lidar_range_to_point_cloud_core: drives range items and register writes,
// predicts every point item in its own model and compares field by field. Depends on lrpc_pkg.
`timescale 1ns / 1ps
module lidar_range_to_point_cloud_core_tb;
    import lrpc_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ok;
        logic signed [31:0] rng;
        logic               last;
    } point_t;

    localparam longint LIMIT = 3000000;
    localparam longint PI_A = 843314857;
    localparam longint HPI_A = 421657428;
    localparam longint GAIN_A = 652032874;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_range_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_point_x, m_point_y, m_point_z, m_range_out;
    logic m_in_range, m_last_of_scan;

    lidar_range_to_point_cloud_core i_dut (.*);

    always #6 aclk = ~aclk;

    logic [31:0] az_start, az_step, el_start, el_step, rmin, rmax;
    logic [12:0] n_cols;
    logic [8:0]  n_rows;
    int unsigned col_idx, row_idx;
    point_t expected_points[$];
    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_off = 0;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint arctan_entry(int i);
        longint tab[30] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
            4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
        return tab[i];
    endfunction

    task automatic cos_sin(input logic [31:0] angle, output longint c, output longint s);
        longint ang, cx, sy, t;
        bit flip;
        ang = longint'($signed(angle));
        cx = GAIN_A;
        sy = 0;
        flip = 0;
        for (int i = 0; i < 4; i++) begin
            if (ang > HPI_A) begin
                ang -= PI_A;
                flip = ~flip;
            end else if (ang < -HPI_A) begin
                ang += PI_A;
                flip = ~flip;
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 30; i++) begin
            if (ang >= 0) begin
                t = cx - floor_shift(sy, i);
                sy = sy + floor_shift(cx, i);
                ang -= arctan_entry(i);
            end else begin
                t = cx + floor_shift(sy, i);
                sy = sy - floor_shift(cx, i);
                ang += arctan_entry(i);
            end
            cx = t;
        end
        c = flip ? -cx : cx;
        s = flip ? -sy : sy;
    endtask

    task automatic predict_point(input logic signed [31:0] r);
        point_t p;
        int unsigned cols, nrows;
        bit col_last, row_last;
        logic [31:0] az, el;
        longint ca, sa, ce, se, rl;
        cols = (n_cols == 0) ? 1 : (n_cols > MAX_COLUMNS ? MAX_COLUMNS : n_cols);
        nrows = (n_rows == 0) ? 1 : (n_rows > MAX_ROWS ? MAX_ROWS : n_rows);
        col_last = col_idx + 1 >= cols;
        row_last = row_idx + 1 >= nrows;
        p = '0;
        p.ok = ($signed(r) >= $signed(rmin)) && ($signed(r) <= $signed(rmax));
        p.rng = r;
        p.last = col_last && row_last;
        az = (cols > 1) ? az_start + col_idx * az_step : 32'd0;
        el = el_start + row_idx * el_step;
        if (nrows > 1 && p.ok) begin
            rl = longint'(r);
            cos_sin(az, ca, sa);
            cos_sin(el, ce, se);
            p.x = clip32(round_q30(round_q30(ca * ce) * rl));
            p.y = clip32(round_q30(round_q30(sa * ce) * rl));
            p.z = clip32(round_q30(se * rl));
        end
        expected_points.insert(expected_points.size(), p);
        if (col_last) begin
            col_idx = 0;
            row_idx = row_last ? 0 : row_idx + 1;
        end else begin
            col_idx++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        point_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected item", m_range_out, 32'd0);
            end else begin
                w = expected_points.pop_front();
                if (m_point_x !== w.x) report_mismatch("point_x", m_point_x, w.x);
                if (m_point_y !== w.y) report_mismatch("point_y", m_point_y, w.y);
                if (m_point_z !== w.z) report_mismatch("point_z", m_point_z, w.z);
                if (m_in_range !== w.ok) report_mismatch("in_range", m_in_range, w.ok);
                if (m_range_out !== w.rng) report_mismatch("range_out", m_range_out, w.rng);
                if (m_last_of_scan !== w.last)
                    report_mismatch("last_of_scan", m_last_of_scan, w.last);
            end
        end
    end

    task automatic send_range(input logic [31:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_range_in <= r;
        predict_point(r);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_AZ_START: az_start = v;
            REG_AZ_STEP:  az_step = v;
            REG_EL_START: el_start = v;
            REG_EL_STEP:  el_step = v;
            REG_COLUMNS:  n_cols = v[12:0];
            REG_ROWS:     n_rows = v[8:0];
            REG_RMIN:     rmin = v;
            default:      rmax = v;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_scan(input logic [31:0] as, input logic [31:0] ast,
                            input logic [31:0] es, input logic [31:0] est,
                            input logic [31:0] c, input logic [31:0] r);
        write_reg(REG_AZ_START, as);
        write_reg(REG_AZ_STEP, ast);
        write_reg(REG_EL_START, es);
        write_reg(REG_EL_STEP, est);
        write_reg(REG_COLUMNS, c);
        write_reg(REG_ROWS, r);
    endtask

    function automatic logic [31:0] random_range();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h0400_0000);
            default: return $urandom_range(rmax, rmin);
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_range(32'd0);
        send_range(32'h03e8_0000);
        send_range(32'h03e8_0001);
        send_range(32'hffff_ffff);
        drain();
    endtask

    task automatic test_directed_3d;
        set_scan(32'hf36f_0000, 32'h0080_0000, 32'hfc00_0000, 32'h0200_0000, 3, 3);
        write_reg(REG_RMIN, 32'h8000_0000);
        write_reg(REG_RMAX, 32'h7fff_ffff);
        send_range(32'h7fff_ffff);
        send_range(32'h8000_0000);
        send_range(32'h0001_0000);
        send_range(32'h0000_0000);
        send_range(32'h0000_0001);
        send_range(32'hffff_0000);
        send_range(32'h0064_8000);
        send_range(32'h5555_5555);
        send_range(32'haaaa_aaaa);
        drain();
        set_scan(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 2);
        write_reg(REG_RMIN, 32'h0010_0000);
        write_reg(REG_RMAX, 32'h000f_0000);
        send_range(32'h0010_0000);
        send_range(32'h000f_8000);
        drain();
        set_scan(32'd0, 32'd0, 32'd0, 32'd0, 0, 0);
        write_reg(REG_RMIN, 32'd0);
        write_reg(REG_RMAX, 32'h7fff_ffff);
        send_range(32'h0123_4567);
        drain();
        set_scan(32'h1000_0000, 32'h0000_1000, 32'hf000_0000, 32'h0010_0000, 8191, 511);
        send_range(32'h7fff_ffff);
        send_range(32'h0100_0000);
        drain();
    endtask

    task automatic run_random(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        set_scan($urandom(), $urandom_range(32'h0100_0000), $urandom(),
                 $urandom_range(32'h0100_0000), $urandom_range(1, 12), $urandom_range(2, 6));
        write_reg(REG_RMIN, $urandom_range(32'h0100_0000));
        write_reg(REG_RMAX, $urandom_range(32'h7fff_ffff, 32'h0200_0000));
        for (int i = 0; i < n; i++) send_range(random_range());
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 400;
        for (int i = 0; i < 20; i++) send_range(random_range());
        drain();
    endtask

    task automatic test_2d_mode;
        set_scan($urandom(), $urandom(), $urandom(), $urandom(), 4096, 1);
        write_reg(REG_RMIN, 32'hffff_0000);
        write_reg(REG_RMAX, 32'h0100_0000);
        for (int i = 0; i < 60; i++) send_range($urandom());
        drain();
    endtask

    initial begin
        az_start = 0; az_step = 0; el_start = 0; el_step = 0;
        n_cols = 1; n_rows = 1; rmin = 0; rmax = RANGE_MAX_RESET;
        col_idx = 0; row_idx = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_3d();
        run_random(250, 0, 0);
        test_backpressure();
        run_random(250, 83, 0);
        run_random(250, 0, 83);
        run_random(250, 33, 33);
        test_2d_mode();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
